// ----- src/address_keyed_slot_table_macros.svh -----
// Assertion macros for the address keyed slot table.
// Included by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef ADDRESS_KEYED_SLOT_TABLE_MACROS_SVH
`define ADDRESS_KEYED_SLOT_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define AKST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot table check failed");
`define AKST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot table check failed");
`else
`define AKST_ASSERT_SAME(label, ante, cons)
`define AKST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/akst_pkg.sv -----
// Shared types and constants for the address keyed slot table.
// Used by akst_cell and address_keyed_slot_table; depends on nothing.
package akst_pkg;

  localparam int ENTRIES    = 16;
  localparam int STAMP_BITS = 32;
  localparam int KEY_W      = 48;
  localparam int TICK_W     = 32;
  localparam int FUNC_W     = 2;
  localparam int TS_W       = 5;
  localparam int SLOT_W     = 4;
  localparam int LIVE_W     = 5;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  // Width at which a cell index is compared against the table size.
  localparam int CMP_W      = (TS_W > IDX_W) ? TS_W : IDX_W + 1;
  // Width at which the live count is compared against the usable size.
  localparam int USE_W      = (TS_W > CNT_W) ? TS_W : CNT_W;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  localparam int REG_TABLE_SIZE = 0;
  localparam logic [TS_W-1:0] TABLE_SIZE_RESET = 5'd16;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  device_addr;
    logic [TICK_W-1:0] now_ticks;
  } item_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [LIVE_W-1:0] live_count;
  } result_t;

  // Command token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic              armed;
    logic [FUNC_W-1:0] func;
    key_t              key;
    stamp_t            stamp;
    logic              found;
    idx_t              slot;
  } token_t;

endpackage

// ----- src/akst_cell.sv -----
// One slot of the table: holds a key and a timestamp and passes the command token on.
// Depends on akst_pkg.
module akst_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  akst_pkg::idx_t            cell_index,
  input  logic [akst_pkg::TS_W-1:0] limit,
  input  akst_pkg::token_t          tin,
  output akst_pkg::token_t          tout
);

  akst_pkg::key_t   key;
  akst_pkg::stamp_t stamp;
  akst_pkg::key_t   match_key;
  akst_pkg::token_t tout_next;
  logic             in_range;
  logic             hit;

  assign match_key = (tin.func == akst_pkg::FUNC_ADD) ? '0 : tin.key;
  assign in_range  = akst_pkg::CMP_W'(cell_index) < akst_pkg::CMP_W'(limit);
  // Only the first matching slot in use acts; later cells see the found flag.
  assign hit = tin.valid && tin.armed && !tin.found && in_range && (key == match_key);

  always_comb begin
    tout_next       = tin;
    tout_next.found = tin.found || hit;
    tout_next.slot  = hit ? cell_index : tin.slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key  <= '0;
      tout <= '0;
    end else begin
      tout <= tout_next;
      if (hit && tin.func == akst_pkg::FUNC_ADD) begin
        key <= tin.key;
      end else if (hit && tin.func == akst_pkg::FUNC_REMOVE) begin
        key <= '0;
      end
    end
  end

  // The timestamp has no reset value; it is defined once written.
  always_ff @(posedge clk) begin
    if (hit && tin.func != akst_pkg::FUNC_REMOVE) begin
      stamp <= tin.stamp;
    end
  end

endmodule

// ----- src/address_keyed_slot_table.sv -----
// Top level of the address keyed slot table: command port, register port, cell row.
// Depends on akst_pkg, akst_cell and address_keyed_slot_table_macros.svh.
//
//  channel   | direction | handshake                               | payload
//  ----------+-----------+-----------------------------------------+------------------
//  item      | in        | start high while busy low               | item   (item_t)
//  result    | out       | done high for one cycle, cannot stall   | result (result_t)
//  registers | in/out    | psel, penable, pwrite high, pready high | pwdata / prdata
//
// From accept to result, each command is loaded into the head register, passes
// through the register of every cell as it walks the row, and has its result
// registered. busy stays high until the result is registered, so one
// command is in flight at a time. The result strobe comes in the cycle after
// the token leaves the last cell; the receiver takes it without stalling.
// Reset empties every slot, zeroes the live count and sets table_size to 16.
`include "address_keyed_slot_table_macros.svh"

module address_keyed_slot_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  akst_pkg::item_t           item,
  output logic                      done,
  output akst_pkg::result_t         result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [akst_pkg::TS_W-1:0]  table_size;
  akst_pkg::cnt_t             count;
  akst_pkg::cnt_t             count_next;
  logic [akst_pkg::USE_W-1:0] usable;
  logic                       accept;
  logic                       armed;
  logic                       reg_hit;
  akst_pkg::token_t           head;
  akst_pkg::token_t           link [akst_pkg::ENTRIES+1];
  akst_pkg::token_t           tail;

  // Register port. The only register, table_size, sits at byte address 0;
  // paddr[2] selects the register index, so other words read as zero.
  assign pready  = 1'b1;
  assign reg_hit = (32'(paddr[2]) == akst_pkg::REG_TABLE_SIZE);
  assign prdata  = reg_hit ? 32'(table_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= akst_pkg::TABLE_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      table_size <= pwdata[akst_pkg::TS_W-1:0];
    end
  end

  // A size above the built depth acts as the full depth.
  assign usable = (akst_pkg::USE_W'(table_size) > akst_pkg::USE_W'(akst_pkg::ENTRIES)) ?
                  akst_pkg::USE_W'(akst_pkg::ENTRIES) : akst_pkg::USE_W'(table_size);

  assign accept = start && !busy;

  // Decide at entry whether the command may act at all. A zero key is always
  // refused, an add needs room under the usable size, and an unused function
  // code changes nothing.
  always_comb begin
    case (item.func)
      akst_pkg::FUNC_ADD:    armed = akst_pkg::USE_W'(count) < usable;
      akst_pkg::FUNC_LOOKUP: armed = 1'b1;
      akst_pkg::FUNC_REMOVE: armed = 1'b1;
      default:               armed = 1'b0;
    endcase
    if (item.device_addr == '0) begin
      armed = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head.valid <= accept;
      if (accept) begin
        head.armed <= armed;
        head.func  <= item.func;
        head.key   <= item.device_addr;
        head.stamp <= akst_pkg::STAMP_BITS'(item.now_ticks);
        head.found <= 1'b0;
        head.slot  <= '0;
      end
    end
  end

  // The row of cells. Cell i holds slot i; the token visits the cells in index
  // order, and the first matching slot in use claims the command.
  assign link[0] = head;

  for (genvar i = 0; i < akst_pkg::ENTRIES; i++) begin : g_cell
    akst_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (akst_pkg::idx_t'(i)),
      .limit      (table_size),
      .tin        (link[i]),
      .tout       (link[i+1])
    );
  end

  assign tail = link[akst_pkg::ENTRIES];

  // Live count follows the outcome once the token has passed every slot.
  always_comb begin
    count_next = count;
    if (tail.found && tail.func == akst_pkg::FUNC_ADD) begin
      count_next = count + akst_pkg::cnt_t'(1);
    end else if (tail.found && tail.func == akst_pkg::FUNC_REMOVE && count != '0) begin
      count_next = count - akst_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= tail.valid;
      if (tail.valid) begin
        count <= count_next;
        busy  <= 1'b0;
      end else if (accept) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      result.ok         <= tail.found;
      result.slot       <= tail.found ? akst_pkg::SLOT_W'(tail.slot) : '0;
      result.live_count <= akst_pkg::LIVE_W'(count_next);
    end
  end

  // An accepted command holds the block busy on the next cycle.
  `AKST_ASSERT_NEXT(a_busy_after_accept, accept, busy)
  // The result transfer ends the command, so the strobe never meets busy.
  `AKST_ASSERT_SAME(a_done_not_busy, done, !busy)
  // A refused or unmatched command reports slot zero.
  `AKST_ASSERT_SAME(a_slot_zero_on_miss, done && !result.ok, result.slot == '0)
  // The live count can never exceed the built depth.
  `AKST_ASSERT_SAME(a_count_bound, 1'b1, 32'(count) <= akst_pkg::ENTRIES)

endmodule
